// File: rtl/swps_pkg.sv
package swps_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WIDTH_BITS      = 7;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(1);

endpackage

// File: rtl/swps_cell.sv
module swps_cell #(
    parameter int WINDOW_MAX  = swps_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swps_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX       = 0,
    localparam int CW         = $clog2(WINDOW_MAX + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    output logic [SAMPLE_BITS-1:0] sample_out,
    input  logic [CW-1:0]          win_width,
    input  logic                   tok_in,
    input  logic [SAMPLE_BITS-1:0] lo_in,
    input  logic [SAMPLE_BITS-1:0] hi_in,
    output logic                   tok_out,
    output logic [SAMPLE_BITS-1:0] lo_out,
    output logic [SAMPLE_BITS-1:0] hi_out
);

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic [SAMPLE_BITS-1:0] hi_reg, hi_next;
    logic                   tok_reg;
    logic                   active;

    assign active = CW'(INDEX) < win_width;

    always_comb begin
        lo_next = lo_in;
        hi_next = hi_in;
        if (active) begin
            if (sample_reg < lo_in) begin
                lo_next = sample_reg;
            end
            if (sample_reg > hi_in) begin
                hi_next = sample_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
        end else begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sample_reg <= sample_in;
        end
        if (tok_in) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign sample_out = sample_reg;
    assign tok_out    = tok_reg;
    assign lo_out     = lo_reg;
    assign hi_out     = hi_reg;

endmodule

// File: rtl/sliding_window_peak_spread_top.sv
// Takes a run of unsigned samples (s_last marks the final word of a run) and returns, for
// each run, the largest max-minus-min over any window_width consecutive samples, or 0 if
// the run never filled a window. Samples live in a row of WINDOW_MAX cells; for every
// sample that completes a window a min/max token walks the whole row, one cell per cycle,
// and no new sample is taken until it leaves the row; a final sample then hands off its
// result, with s_ready low while an earlier result still waits on m_ready. window_width
// is clamped to WINDOW_MAX, a width of 0 yields 0, and a write applies from the next
// accepted word, also within a run.
module sliding_window_peak_spread_top #(
    parameter int WINDOW_MAX  = swps_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [swps_pkg::WIDTH_BITS-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [SAMPLE_BITS-1:0]          s_sample,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [SAMPLE_BITS-1:0]          m_peak_spread
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int WB = swps_pkg::WIDTH_BITS;
    localparam int XW = (CW > WB) ? CW : WB;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [WB-1:0]          width_reg;
    logic [CW-1:0]          seen_reg;
    logic [CW-1:0]          wlat_reg;
    logic [SAMPLE_BITS-1:0] best_reg;
    logic                   last_reg;
    logic                   start_reg;
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_peak_reg;

    logic                   accept;
    logic                   emit_fire;
    logic [XW-1:0]          width_ext;
    logic [CW-1:0]          w_eff;
    logic [CW-1:0]          seen_next;
    logic                   qualify;
    logic [SAMPLE_BITS-1:0] spread;
    logic [SAMPLE_BITS-1:0] best_next;

    logic [SAMPLE_BITS-1:0] smp_chain [WINDOW_MAX+1];
    logic [SAMPLE_BITS-1:0] lo_chain  [WINDOW_MAX+1];
    logic [SAMPLE_BITS-1:0] hi_chain  [WINDOW_MAX+1];
    logic                   tok_chain [WINDOW_MAX+1];

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign width_ext = XW'(width_reg);
    assign w_eff     = (width_ext > XW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(width_ext);
    assign seen_next = (seen_reg == CW'(WINDOW_MAX)) ? seen_reg : seen_reg + CW'(1);
    assign qualify   = (w_eff != '0) && (seen_next >= w_eff);

    assign smp_chain[0] = s_sample;
    assign tok_chain[0] = start_reg;
    assign lo_chain[0]  = '1;
    assign hi_chain[0]  = '0;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        swps_cell #(
            .WINDOW_MAX (WINDOW_MAX),
            .SAMPLE_BITS(SAMPLE_BITS),
            .INDEX      (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (accept),
            .sample_in (smp_chain[i]),
            .sample_out(smp_chain[i+1]),
            .win_width (wlat_reg),
            .tok_in    (tok_chain[i]),
            .lo_in     (lo_chain[i]),
            .hi_in     (hi_chain[i]),
            .tok_out   (tok_chain[i+1]),
            .lo_out    (lo_chain[i+1]),
            .hi_out    (hi_chain[i+1])
        );
    end

    assign spread    = hi_chain[WINDOW_MAX] - lo_chain[WINDOW_MAX];
    assign best_next = (spread > best_reg) ? spread : best_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= swps_pkg::WIDTH_RESET;
            seen_reg    <= '0;
            wlat_reg    <= '0;
            best_reg    <= '0;
            last_reg    <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= accept && qualify;
            if (cfg_we) begin
                width_reg <= cfg_wdata;
            end
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        seen_reg <= seen_next;
                        wlat_reg <= w_eff;
                        last_reg <= s_last;
                        if (qualify) begin
                            state_reg <= ST_SWEEP;
                        end else if (s_last) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (tok_chain[WINDOW_MAX]) begin
                        best_reg  <= best_next;
                        state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        m_peak_reg  <= best_reg;
                        best_reg    <= '0;
                        seen_reg    <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_peak_spread = m_peak_reg;

endmodule
